// ----- hw/rtl/cdtd_pkg.sv -----
// ============================================================================
// cdtd_pkg
// Shared constants, codes and types of the countdown task dispatcher.
// ============================================================================
package cdtd_pkg;

    localparam int MAX_TASKS    = 16;
    localparam int ID_BITS      = 8;
    localparam int PERIOD_BITS  = 16;
    localparam int PERIOD_EXTRA = 2;
    localparam int IDX_W        = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W        = $clog2(MAX_TASKS + 1);
    localparam int ENTRY_W      = ID_BITS + 2 * PERIOD_BITS;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_CREATE = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_EMPTY     = 2'd2;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [ID_BITS-1:0]     id;
        logic [PERIOD_BITS-1:0] period;
        logic [PERIOD_BITS-1:0] countdown;
    } entry_t;

    typedef struct packed {
        logic fire;
        logic match;
    } entry_flags_t;

endpackage

// ----- hw/rtl/cdtd_ram.sv -----
// ============================================================================
// cdtd_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module cdtd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/cdtd_entry_unit.sv -----
// ============================================================================
// cdtd_entry_unit
// Shared per-entry unit: countdown decrement with reload, and id compare.
// ============================================================================
module cdtd_entry_unit
    import cdtd_pkg::*;
(
    input  entry_t             entry,
    input  logic [ID_BITS-1:0] key_id,
    output entry_t             ticked,
    output entry_flags_t       flags
);

    logic [PERIOD_BITS-1:0] dec;

    assign dec         = entry.countdown - PERIOD_BITS'(1);
    assign flags.fire  = (dec == '0);
    assign flags.match = (entry.id == key_id);

    always_comb
    begin
        ticked           = entry;
        ticked.countdown = flags.fire ? entry.period : dec;
    end

endmodule

// ----- hw/rtl/countdown_task_dispatcher_unit.sv -----
// ============================================================================
// countdown_task_dispatcher_unit
// Ordered task table with create, delete and countdown tick walk.
// ============================================================================
// Create, full-table create, empty-table delete and unused codes: one result
// in the cycle after the transfer; busy stays low.
// Tick and delete: busy while the table is walked, one entry per cycle
// through the single RAM read port and the shared entry unit.
// Results come one per strobe cycle; the receiver cannot stall.
// Reset clears the entry count and control; table contents are not cleared.
module countdown_task_dispatcher_unit
    import cdtd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             operation,
    input  logic [ID_BITS-1:0]     task_id,
    input  logic [PERIOD_BITS-1:0] priority_req,
    output logic                   result_valid,
    output logic [ID_BITS-1:0]     fired_id,
    output logic                   fired,
    output logic [1:0]             status,
    output logic                   last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_SEARCH,
        ST_SHIFT
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   issue_reg, issue_next;
    logic               s1_valid_reg, s1_valid_next;
    logic [IDX_W-1:0]   s1_idx_reg, s1_idx_next;
    logic [ID_BITS-1:0] key_reg, key_next;
    logic               pend_reg, pend_next;
    logic [ID_BITS-1:0] pend_id_reg, pend_id_next;

    logic               rv_reg, rv_next;
    logic [ID_BITS-1:0] fid_reg, fid_next;
    logic               fired_reg, fired_next;
    logic [1:0]         status_reg, status_next;
    logic               last_reg, last_next;

    logic               we;
    logic [IDX_W-1:0]   waddr;
    entry_t             wdata;
    logic [IDX_W-1:0]   raddr;
    logic [ENTRY_W-1:0] rdata;
    entry_t             rd_entry;
    entry_t             ticked;
    entry_flags_t       flags;

    logic [PERIOD_BITS:0]   period_sum;
    logic [PERIOD_BITS-1:0] period_sat;
    logic                   issue_more;

    cdtd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_entry = entry_t'(rdata);

    cdtd_entry_unit u_entry (
        .entry  (rd_entry),
        .key_id (key_reg),
        .ticked (ticked),
        .flags  (flags)
    );

    assign period_sum = {1'b0, priority_req} + (PERIOD_BITS + 1)'(PERIOD_EXTRA);
    assign period_sat = period_sum[PERIOD_BITS] ? '1 : period_sum[PERIOD_BITS-1:0];
    assign issue_more = (issue_reg < count_reg);
    assign raddr      = issue_reg[IDX_W-1:0];
    assign busy       = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        issue_next    = issue_reg;
        s1_valid_next = 1'b0;
        s1_idx_next   = s1_idx_reg;
        key_next      = key_reg;
        pend_next     = pend_reg;
        pend_id_next  = pend_id_reg;
        rv_next       = 1'b0;
        fid_next      = '0;
        fired_next    = 1'b0;
        status_next   = STATUS_OK;
        last_next     = 1'b0;
        we            = 1'b0;
        waddr         = s1_idx_reg;
        wdata         = ticked;

        if (state_reg != ST_IDLE && issue_more)
        begin
            issue_next    = issue_reg + CNT_W'(1);
            s1_valid_next = 1'b1;
            s1_idx_next   = issue_reg[IDX_W-1:0];
        end

        case (state_reg)
            ST_IDLE:
            begin
                issue_next = '0;
                pend_next  = 1'b0;
                key_next   = task_id;
                if (start)
                begin
                    rv_next   = 1'b1;
                    last_next = 1'b1;
                    case (operation)
                        OP_TICK:
                        begin
                            rv_next    = 1'b0;
                            last_next  = 1'b0;
                            state_next = ST_TICK;
                        end
                        OP_CREATE:
                        begin
                            if (count_reg == CNT_W'(MAX_TASKS))
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                we               = 1'b1;
                                waddr            = count_reg[IDX_W-1:0];
                                wdata.id         = task_id;
                                wdata.period     = period_sat;
                                wdata.countdown  = period_sat;
                                count_next       = count_reg + CNT_W'(1);
                            end
                        end
                        OP_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                rv_next    = 1'b0;
                                last_next  = 1'b0;
                                state_next = ST_SEARCH;
                            end
                        end
                        default:
                        begin
                            status_next = STATUS_OK;
                        end
                    endcase
                end
            end

            ST_TICK:
            begin
                if (s1_valid_reg)
                begin
                    we    = 1'b1;
                    waddr = s1_idx_reg;
                    wdata = ticked;
                    if (flags.fire)
                    begin
                        if (pend_reg)
                        begin
                            rv_next    = 1'b1;
                            fid_next   = pend_id_reg;
                            fired_next = 1'b1;
                        end
                        pend_next    = 1'b1;
                        pend_id_next = rd_entry.id;
                    end
                end
                else if (!issue_more)
                begin
                    rv_next    = 1'b1;
                    last_next  = 1'b1;
                    fired_next = pend_reg;
                    fid_next   = pend_reg ? pend_id_reg : '0;
                    state_next = ST_IDLE;
                end
            end

            ST_SEARCH:
            begin
                if (s1_valid_reg)
                begin
                    if (flags.match)
                    begin
                        state_next = ST_SHIFT;
                    end
                end
                else if (!issue_more)
                begin
                    rv_next     = 1'b1;
                    last_next   = 1'b1;
                    status_next = STATUS_NOT_FOUND;
                    state_next  = ST_IDLE;
                end
            end

            ST_SHIFT:
            begin
                if (s1_valid_reg)
                begin
                    we    = 1'b1;
                    waddr = s1_idx_reg - IDX_W'(1);
                    wdata = rd_entry;
                end
                else if (!issue_more)
                begin
                    count_next = count_reg - CNT_W'(1);
                    rv_next    = 1'b1;
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            issue_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s1_idx_reg   <= '0;
            key_reg      <= '0;
            pend_reg     <= 1'b0;
            pend_id_reg  <= '0;
            rv_reg       <= 1'b0;
            fid_reg      <= '0;
            fired_reg    <= 1'b0;
            status_reg   <= STATUS_OK;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            issue_reg    <= issue_next;
            s1_valid_reg <= s1_valid_next;
            s1_idx_reg   <= s1_idx_next;
            key_reg      <= key_next;
            pend_reg     <= pend_next;
            pend_id_reg  <= pend_id_next;
            rv_reg       <= rv_next;
            fid_reg      <= fid_next;
            fired_reg    <= fired_next;
            status_reg   <= status_next;
            last_reg     <= last_next;
        end
    end

    assign result_valid = rv_reg;
    assign fired_id     = fid_reg;
    assign fired        = fired_reg;
    assign status       = status_reg;
    assign last         = last_reg;

endmodule
